FILE: sv/hpi_pkg.sv
// ----------------------------------------------------------------------------
// hpi_pkg
// Shared types and constants of the homopolymer indel injector.
// ----------------------------------------------------------------------------
package hpi_pkg;

    // default rate table depth
    localparam int TABLE_DEPTH_DEF = 16;

    // field widths
    localparam int CFG_W   = 5;
    localparam int BASE_W  = 2;
    localparam int ERR_W   = 2;
    localparam int ENTRY_W = 4;
    localparam int RATE_W  = 32;
    localparam int RUN_W   = 5;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    // register map (byte addresses)
    localparam logic [APB_AW-1:0] ADDR_TABLE_ENTRIES = 3'd0;

    // item kinds
    localparam logic REQ_BASE = 1'b0;
    localparam logic REQ_LOAD = 1'b1;

    // error codes
    typedef enum logic [ERR_W-1:0] {
        ERR_NONE  = 2'd0,
        ERR_SUBST = 2'd1,
        ERR_DEL   = 2'd2,
        ERR_INS   = 2'd3
    } t_err;

    // indel direction of the current run
    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_INS  = 2'd1,
        DIR_DEL  = 2'd2
    } t_dir;

    // one input beat
    typedef struct packed {
        logic              req_type;
        logic              new_read;
        logic [BASE_W-1:0] base;
        logic [RATE_W-1:0] random_value;
        logic [ERR_W-1:0]  prior_error;
        logic [ENTRY_W-1:0] entry_index;
        logic [RATE_W-1:0] deletion_rate;
        logic [RATE_W-1:0] insertion_rate;
    } t_item;

    // control handed from the run tracker to the indel decision stage
    typedef struct packed {
        logic              is_load;
        logic              new_run;
        logic              hit;
        logic [ERR_W-1:0]  prior_error;
        logic [RATE_W-1:0] random_value;
        logic [RUN_W-1:0]  run_length;
    } t_stage_b;

endpackage

FILE: sv/hpi_ram.sv
// ----------------------------------------------------------------------------
// hpi_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module hpi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/hpi_run_track.sv
// ----------------------------------------------------------------------------
// hpi_run_track
// Run tracking and rate table access: updates last base and run length,
// writes rate entries on load beats and reads the entry for the run length.
// ----------------------------------------------------------------------------
module hpi_run_track #(
    parameter int TABLE_DEPTH = hpi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_adv,
    input  logic                      i_a_valid,
    input  hpi_pkg::t_item            i_a_item,
    input  logic [hpi_pkg::CFG_W-1:0] i_cfg_entries,
    output logic                      o_b_valid,
    output hpi_pkg::t_stage_b         o_b_ctl,
    output logic [2*hpi_pkg::RATE_W-1:0] o_rates
);
    import hpi_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int EW = (CW > CFG_W) ? CW : CFG_W;

    logic [BASE_W-1:0]      r_last_base;
    logic                   r_run_active;
    logic [CW-1:0]          r_count;
    logic [TABLE_DEPTH-1:0] r_loaded;
    logic                   r_b_valid;
    t_stage_b               r_b_ctl;

    logic [BASE_W-1:0] n_last_base;
    logic              n_run_active;
    logic [CW-1:0]     n_count;
    logic              new_run;
    logic              is_load;
    logic              load_ok;
    logic [EW-1:0]     cfg_e;
    logic [EW-1:0]     eff;
    logic [EW-1:0]     lim;
    logic [EW-1:0]     cnt_e;
    logic [EW-1:0]     idx;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;
    logic              rd_en;

    assign is_load = (i_a_item.req_type == REQ_LOAD);
    assign load_ok = (32'(i_a_item.entry_index) < 32'(TABLE_DEPTH));

    // a new run starts on a new read, with no run yet, or on a changed base
    assign new_run = i_a_item.new_read || !r_run_active || (i_a_item.base != r_last_base);

    // next run state
    always_comb begin
        n_last_base  = r_last_base;
        n_run_active = r_run_active;
        n_count      = r_count;
        if (!is_load) begin
            if (new_run) begin
                n_last_base  = i_a_item.base;
                n_run_active = 1'b1;
                n_count      = CW'(1);
            end else if (r_count < CW'(TABLE_DEPTH)) begin
                n_count = r_count + 1'b1;
            end
        end
    end

    // table index: run length clamped to the last configured entry
    always_comb begin
        cfg_e = EW'(i_cfg_entries);
        if (cfg_e == '0) begin
            eff = EW'(1);
        end else if (cfg_e > EW'(TABLE_DEPTH)) begin
            eff = EW'(TABLE_DEPTH);
        end else begin
            eff = cfg_e;
        end
        lim   = eff - 1'b1;
        cnt_e = EW'(n_count);
        idx   = (cnt_e < lim) ? cnt_e : lim;
    end

    assign rd_addr = AW'(idx);
    assign wr_addr = AW'(i_a_item.entry_index);
    assign wr_en   = i_adv && i_a_valid && is_load && load_ok;
    assign rd_en   = i_adv;

    // rate table: insertion rate in the upper half, deletion in the lower
    hpi_ram #(
        .WIDTH (2 * RATE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_rates (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({i_a_item.insertion_rate, i_a_item.deletion_rate}),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (o_rates)
    );

    // run state and loaded flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_base  <= '0;
            r_run_active <= 1'b0;
            r_count      <= '0;
            r_loaded     <= '0;
        end else if (i_adv && i_a_valid) begin
            r_last_base  <= n_last_base;
            r_run_active <= n_run_active;
            r_count      <= n_count;
            if (wr_en) begin
                r_loaded[wr_addr] <= 1'b1;
            end
        end
    end

    // stage B valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (i_adv) begin
            r_b_valid <= i_a_valid;
        end
    end

    // stage B payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_b_ctl.is_load      <= is_load;
            r_b_ctl.new_run      <= new_run;
            r_b_ctl.hit          <= r_loaded[rd_addr];
            r_b_ctl.prior_error  <= i_a_item.prior_error;
            r_b_ctl.random_value <= i_a_item.random_value;
            r_b_ctl.run_length   <= RUN_W'(n_count);
        end
    end

    assign o_b_valid = r_b_valid;
    assign o_b_ctl   = r_b_ctl;

endmodule

FILE: sv/hpi_indel_decide.sv
// ----------------------------------------------------------------------------
// hpi_indel_decide
// Compares the random word against the selected rates, keeps the indel
// direction of the run and holds the result register.
// ----------------------------------------------------------------------------
module hpi_indel_decide (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_adv,
    input  logic                        i_b_valid,
    input  hpi_pkg::t_stage_b           i_b_ctl,
    input  logic [2*hpi_pkg::RATE_W-1:0] i_rates,
    output logic                        o_valid,
    output logic [hpi_pkg::ERR_W-1:0]   o_error_type,
    output logic [hpi_pkg::RUN_W-1:0]   o_run_length
);
    import hpi_pkg::*;

    t_dir              r_dir;
    t_dir              n_dir;
    t_err              err;
    logic              r_out_valid;
    logic [ERR_W-1:0]  r_error_type;
    logic [RUN_W-1:0]  r_run_length;
    logic [RATE_W-1:0] del_rate;
    logic [RATE_W-1:0] ins_rate;
    logic [RATE_W:0]   sum_rate;
    logic              hit_del;
    logic              hit_ins;
    logic              hit_sum;

    // entries never loaded read as zero
    assign del_rate = i_b_ctl.hit ? i_rates[RATE_W-1:0] : '0;
    assign ins_rate = i_b_ctl.hit ? i_rates[2*RATE_W-1:RATE_W] : '0;
    assign sum_rate = {1'b0, del_rate} + {1'b0, ins_rate};
    assign hit_del  = (i_b_ctl.random_value < del_rate);
    assign hit_ins  = (i_b_ctl.random_value < ins_rate);
    assign hit_sum  = ({1'b0, i_b_ctl.random_value} < sum_rate);

    // error selection and next direction
    always_comb begin
        err   = t_err'(i_b_ctl.prior_error);
        n_dir = r_dir;
        if (i_b_ctl.is_load) begin
            err = ERR_NONE;
        end else if (i_b_ctl.new_run) begin
            n_dir = DIR_NONE;
        end else begin
            case (r_dir)
                DIR_NONE: begin
                    if (hit_del) begin
                        err   = ERR_DEL;
                        n_dir = DIR_DEL;
                    end else if (hit_sum) begin
                        err   = ERR_INS;
                        n_dir = DIR_INS;
                    end
                end
                DIR_INS: begin
                    if (hit_ins) begin
                        err = ERR_INS;
                    end
                end
                DIR_DEL: begin
                    if (hit_del) begin
                        err = ERR_DEL;
                    end
                end
                default: begin
                    err = t_err'(i_b_ctl.prior_error);
                end
            endcase
        end
    end

    // direction and result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dir       <= DIR_NONE;
            r_out_valid <= 1'b0;
        end else if (i_adv) begin
            r_out_valid <= i_b_valid;
            if (i_b_valid) begin
                r_dir <= n_dir;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_error_type <= err;
            r_run_length <= i_b_ctl.run_length;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_error_type = r_error_type;
    assign o_run_length = r_run_length;

endmodule

FILE: sv/homopolymer_indel_injector.sv
// ----------------------------------------------------------------------------
// homopolymer_indel_injector
// Injects homopolymer deletions and insertions into a base stream using
// per-run-length rate tables loaded through the input channel.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-----------------------------------------
//  input    | i_valid / o_stall  | req_type, new_read, base, random_value,
//           |                    | prior_error, entry_index, rates
//  output   | o_valid / i_stall  | error_type, run_length
//  config   | APB psel/penable   | table_entries at byte address 0
//
//  One beat per cycle while the result side does not stall; a result passes
//  the input register, the rate RAM read register and the result register
//  before it is offered.
//  A stalled result freezes the whole pipe; o_stall follows it directly.
//  Reset clears run state, direction and the per-entry loaded flags; a
//  table entry not yet loaded reads as zero, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module homopolymer_indel_injector #(
    parameter int TABLE_DEPTH = hpi_pkg::TABLE_DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_req_type,
    input  logic                        i_new_read,
    input  logic [hpi_pkg::BASE_W-1:0]  i_base,
    input  logic [hpi_pkg::RATE_W-1:0]  i_random_value,
    input  logic [hpi_pkg::ERR_W-1:0]   i_prior_error,
    input  logic [hpi_pkg::ENTRY_W-1:0] i_entry_index,
    input  logic [hpi_pkg::RATE_W-1:0]  i_deletion_rate,
    input  logic [hpi_pkg::RATE_W-1:0]  i_insertion_rate,
    // output channel
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [hpi_pkg::ERR_W-1:0]   o_error_type,
    output logic [hpi_pkg::RUN_W-1:0]   o_run_length,
    // configuration port
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [hpi_pkg::APB_AW-1:0]  paddr,
    input  logic [hpi_pkg::APB_DW-1:0]  pwdata,
    output logic [hpi_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import hpi_pkg::*;

    logic [CFG_W-1:0]  r_table_entries;
    logic              r_a_valid;
    t_item             r_a_item;
    logic              adv;
    logic              cfg_wr;
    logic              b_valid;
    t_stage_b          b_ctl;
    logic [2*RATE_W-1:0] rates;

    // pipe moves unless a held result is stalled
    assign adv     = !(o_valid && i_stall);
    assign o_stall = !adv;

    // configuration register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr == ADDR_TABLE_ENTRIES);
    assign prdata = (paddr == ADDR_TABLE_ENTRIES) ? APB_DW'(r_table_entries) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_entries <= CFG_W'(1);
        end else if (cfg_wr) begin
            r_table_entries <= pwdata[CFG_W-1:0];
        end
    end

    // input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (adv) begin
            r_a_valid <= i_valid;
        end
    end

    // input register payload
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_item.req_type       <= i_req_type;
            r_a_item.new_read       <= i_new_read;
            r_a_item.base           <= i_base;
            r_a_item.random_value   <= i_random_value;
            r_a_item.prior_error    <= i_prior_error;
            r_a_item.entry_index    <= i_entry_index;
            r_a_item.deletion_rate  <= i_deletion_rate;
            r_a_item.insertion_rate <= i_insertion_rate;
        end
    end

    hpi_run_track #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_run_track (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_adv         (adv),
        .i_a_valid     (r_a_valid),
        .i_a_item      (r_a_item),
        .i_cfg_entries (r_table_entries),
        .o_b_valid     (b_valid),
        .o_b_ctl       (b_ctl),
        .o_rates       (rates)
    );

    hpi_indel_decide u_indel_decide (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_b_valid    (b_valid),
        .i_b_ctl      (b_ctl),
        .i_rates      (rates),
        .o_valid      (o_valid),
        .o_error_type (o_error_type),
        .o_run_length (o_run_length)
    );

endmodule

FILE: tb/tb_homopolymer_indel_injector.sv
// ----------------------------------------------------------------------------
// tb_homopolymer_indel_injector
// Self-checking testbench for the homopolymer indel injector. A directed
// table covers extremes, every error code, load beats and direction locking.
// Random runs of repeated bases and rate-table loads follow under several
// table_entries settings. Every result beat is checked against an in-bench
// model of run tracking and indel decisions or, on pinned rows, a typed-in
// result. Both sides idle at random; the result side once holds off long.
// ----------------------------------------------------------------------------
module tb_homopolymer_indel_injector;
    import hpi_pkg::*;

    localparam int DEPTH       = TABLE_DEPTH_DEF;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_BEATS = 91;
    localparam int LONG_HOLD   = 120;

    // one result beat
    typedef struct packed {
        t_err             err;
        logic [RUN_W-1:0] len;
    } t_result;

    // one row of the directed table; pinned rows carry a typed-in result
    typedef struct {
        t_item   beat;
        bit      pinned;
        t_result res;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    logic                i_req_type;
    logic                i_new_read;
    logic [BASE_W-1:0]   i_base;
    logic [RATE_W-1:0]   i_random_value;
    logic [ERR_W-1:0]    i_prior_error;
    logic [ENTRY_W-1:0]  i_entry_index;
    logic [RATE_W-1:0]   i_deletion_rate;
    logic [RATE_W-1:0]   i_insertion_rate;
    logic                o_valid;
    logic                i_stall;
    logic [ERR_W-1:0]    o_error_type;
    logic [RUN_W-1:0]    o_run_length;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    // model state of the injector
    logic [BASE_W-1:0]   track_base;
    logic                track_active;
    logic [RUN_W-1:0]    track_len;
    t_dir                track_dir;
    logic [RATE_W-1:0]   del_rates [DEPTH];
    logic [RATE_W-1:0]   ins_rates [DEPTH];
    logic [CFG_W-1:0]    entries_cfg;

    t_result             pending_results[$];
    t_row                directed_rows[$];
    bit                  pin_on;
    t_result             pin_res;
    int                  fail_count;
    int                  results_seen;
    int                  cycle_count;
    bit                  long_hold_done;
    int                  run_left;
    logic [BASE_W-1:0]   run_base;

    homopolymer_indel_injector u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_req_type       (i_req_type),
        .i_new_read       (i_new_read),
        .i_base           (i_base),
        .i_random_value   (i_random_value),
        .i_prior_error    (i_prior_error),
        .i_entry_index    (i_entry_index),
        .i_deletion_rate  (i_deletion_rate),
        .i_insertion_rate (i_insertion_rate),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_error_type     (o_error_type),
        .o_run_length     (o_run_length),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // clock
    initial i_clk = 1'b0;
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Model of one accepted beat: updates run tracking and returns the result
    // ------------------------------------------------------------------------
    function automatic t_result predict_indel(input t_item beat);
        t_result           r;
        int unsigned       eff;
        int unsigned       idx;
        logic [RATE_W-1:0] d;
        logic [RATE_W-1:0] ins;
        r.err = t_err'(beat.prior_error);
        if (beat.req_type == REQ_LOAD) begin
            // index is 4 bits, so it always lands inside the table
            del_rates[beat.entry_index] = beat.deletion_rate;
            ins_rates[beat.entry_index] = beat.insertion_rate;
            r.err = ERR_NONE;
            r.len = track_len;
            return r;
        end
        if (beat.new_read) begin
            track_active = 1'b0;
            track_len    = '0;
            track_dir    = DIR_NONE;
        end
        if (!track_active || beat.base != track_base) begin
            // new run
            track_base   = beat.base;
            track_active = 1'b1;
            track_len    = RUN_W'(1);
            track_dir    = DIR_NONE;
        end else begin
            if (track_len < DEPTH)
                track_len = track_len + 1'b1;
            // out-of-range register values clamp to 1..DEPTH
            eff = (entries_cfg == 0) ? 1 : ((entries_cfg > DEPTH) ? DEPTH : entries_cfg);
            idx = (track_len < eff - 1) ? track_len : eff - 1;
            d   = del_rates[idx];
            ins = ins_rates[idx];
            case (track_dir)
                DIR_NONE: begin
                    if (beat.random_value < d) begin
                        r.err     = ERR_DEL;
                        track_dir = DIR_DEL;
                    end else if ({1'b0, beat.random_value} < ({1'b0, d} + {1'b0, ins})) begin
                        r.err     = ERR_INS;
                        track_dir = DIR_INS;
                    end
                end
                DIR_INS: begin
                    if (beat.random_value < ins)
                        r.err = ERR_INS;
                end
                DIR_DEL: begin
                    if (beat.random_value < d)
                        r.err = ERR_DEL;
                end
                default: ;
            endcase
        end
        r.len = track_len;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Beat builders and random draws
    // ------------------------------------------------------------------------
    function automatic t_item base_beat(input logic nr, input logic [BASE_W-1:0] b,
                                        input logic [RATE_W-1:0] rnd, input t_err prior);
        t_item it;
        it.req_type       = REQ_BASE;
        it.new_read       = nr;
        it.base           = b;
        it.random_value   = rnd;
        it.prior_error    = prior;
        it.entry_index    = ENTRY_W'($urandom);
        it.deletion_rate  = $urandom;
        it.insertion_rate = $urandom;
        return it;
    endfunction

    function automatic t_item load_beat(input logic [ENTRY_W-1:0] idx,
                                        input logic [RATE_W-1:0] d,
                                        input logic [RATE_W-1:0] ins);
        t_item it;
        it.req_type       = REQ_LOAD;
        it.new_read       = 1'($urandom);
        it.base           = BASE_W'($urandom);
        it.random_value   = $urandom;
        it.prior_error    = ERR_W'($urandom);
        it.entry_index    = idx;
        it.deletion_rate  = d;
        it.insertion_rate = ins;
        return it;
    endfunction

    function automatic logic [RATE_W-1:0] draw_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [RATE_W-1:0] draw_rate();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return $urandom;
            3:       return $urandom >> $urandom_range(1, 12);
            4:       return $urandom_range(0, 255);
            default: return $urandom >> 2;
        endcase
    endfunction

    // mostly runs of one base with random content, loads mixed in
    function automatic t_item next_random_beat();
        logic nr;
        if ($urandom_range(0, 11) == 0)
            return load_beat(ENTRY_W'($urandom), draw_rate(), draw_rate());
        if (run_left == 0) begin
            run_base = BASE_W'($urandom);
            run_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 22)
                                                  : $urandom_range(1, 6);
            nr = ($urandom_range(0, 3) == 0);
        end else begin
            nr = ($urandom_range(0, 30) == 0);
        end
        run_left = run_left - 1;
        return base_beat(nr, run_base, draw_word(), t_err'($urandom_range(0, 3)));
    endfunction

    // idle cycles per beat; in one stretch out of every four it returns zero
    function automatic int draw_gap();
        if ((cycle_count / 500) % 4 == 1)
            return 0;
        return $urandom_range(0, 3);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: offer one beat and wait until it is taken
    // ------------------------------------------------------------------------
    task automatic send_beat(input t_item beat, input bit pinned, input t_result res);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_type       <= beat.req_type;
        i_new_read       <= beat.new_read;
        i_base           <= beat.base;
        i_random_value   <= beat.random_value;
        i_prior_error    <= beat.prior_error;
        i_entry_index    <= beat.entry_index;
        i_deletion_rate  <= beat.deletion_rate;
        i_insertion_rate <= beat.insertion_rate;
        i_valid          <= 1'b1;
        pin_on  = pinned;
        pin_res = res;
        do @(posedge i_clk); while (o_stall);
        @(negedge i_clk);
    endtask

    // lower valid and let the pipe empty before touching the register
    task automatic drain();
        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // APB write of table_entries, then read back
    task automatic set_table_entries(input logic [APB_DW-1:0] value);
        logic [APB_DW-1:0] want;
        want = {{(APB_DW - CFG_W){1'b0}}, value[CFG_W-1:0]};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_TABLE_ENTRIES;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        entries_cfg = value[CFG_W-1:0];
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) begin
            $display("%0t: table_entries readback expected %0d got %0d", $time, want, prdata);
            fail_count = fail_count + 1;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stalls, one long hold-off to back up the pipe
    // ------------------------------------------------------------------------
    initial begin
        int hold;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            hold = draw_gap();
            if (!long_hold_done && results_seen >= 300) begin
                long_hold_done = 1'b1;
                hold = LONG_HOLD;
            end
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
            @(negedge i_clk);
        end
    end

    // ------------------------------------------------------------------------
    // Accepted beats feed the model; result beats are checked in order
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_item   beat;
        t_result want;
        t_result model_res;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                results_seen = results_seen + 1;
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, error_type %0d run_length %0d",
                             $time, o_error_type, o_run_length);
                    fail_count = fail_count + 1;
                end else begin
                    want = pending_results.pop_front();
                    if (o_error_type !== want.err) begin
                        $display("%0t: error_type expected %0d got %0d",
                                 $time, want.err, o_error_type);
                        fail_count = fail_count + 1;
                    end
                    if (o_run_length !== want.len) begin
                        $display("%0t: run_length expected %0d got %0d",
                                 $time, want.len, o_run_length);
                        fail_count = fail_count + 1;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                beat = {i_req_type, i_new_read, i_base, i_random_value, i_prior_error,
                        i_entry_index, i_deletion_rate, i_insertion_rate};
                model_res = predict_indel(beat);
                if (pin_on)
                    model_res = pin_res;
                pending_results = {pending_results, model_res};
            end
        end
    end

    // append one row to the directed table
    function automatic void add_row(input t_item beat, input bit pinned, input t_result res);
        t_row row;
        row.beat   = beat;
        row.pinned = pinned;
        row.res    = res;
        directed_rows = {directed_rows, row};
    endfunction

    // ------------------------------------------------------------------------
    // Directed table: reset table_entries of 1, zeroed tables at first
    // ------------------------------------------------------------------------
    task automatic fill_directed();
        t_result none;
        none = '0;
        // tables empty: no indel, prior error and run length pass through
        add_row(base_beat(1'b1, 2'd0, '0, ERR_NONE), 1'b1, '{ERR_NONE, 5'd1});
        add_row(base_beat(1'b0, 2'd0, '0, ERR_SUBST), 1'b1, '{ERR_SUBST, 5'd2});
        add_row(base_beat(1'b0, 2'd0, '1, ERR_INS), 1'b1, '{ERR_INS, 5'd3});
        // loads keep the run length and give no error
        add_row(load_beat(4'd0, '1, '0), 1'b1, '{ERR_NONE, 5'd3});
        add_row(load_beat(4'd15, '0, '1), 1'b1, '{ERR_NONE, 5'd3});
        add_row(load_beat(4'd1, 32'h8000_0000, 32'h4000_0000), 1'b1, '{ERR_NONE, 5'd3});
        // table_entries of 1: every length reads entry 0, full deletion rate
        add_row(base_beat(1'b0, 2'd0, '0, ERR_NONE), 1'b1, '{ERR_DEL, 5'd4});
        add_row(base_beat(1'b0, 2'd0, '1, ERR_INS), 1'b0, none);
        add_row(base_beat(1'b0, 2'd0, 32'hFFFF_FFFE, ERR_NONE), 1'b0, none);
        // new base starts a new run
        add_row(base_beat(1'b0, 2'd1, '0, ERR_DEL), 1'b1, '{ERR_DEL, 5'd1});
        // small deletion rate, insertion sum past 32 bits
        add_row(load_beat(4'd0, 32'h10, '1), 1'b1, '{ERR_NONE, 5'd1});
        add_row(base_beat(1'b0, 2'd1, 32'h20, ERR_NONE), 1'b0, none);
        // insertion locked: a draw under the deletion rate still inserts
        add_row(base_beat(1'b0, 2'd1, 32'h5, ERR_SUBST), 1'b0, none);
        add_row(base_beat(1'b0, 2'd1, '1, ERR_SUBST), 1'b0, none);
        // new read on the same base restarts the run
        add_row(base_beat(1'b1, 2'd1, '0, ERR_NONE), 1'b1, '{ERR_NONE, 5'd1});
        add_row(base_beat(1'b0, 2'd1, 32'h8, ERR_NONE), 1'b0, none);
        // deletion locked: a draw in the insertion band gives nothing
        add_row(base_beat(1'b0, 2'd1, 32'h30, ERR_NONE), 1'b0, none);
        add_row(base_beat(1'b0, 2'd2, '0, ERR_INS), 1'b1, '{ERR_INS, 5'd1});
        add_row(load_beat(4'd0, '1, '1), 1'b1, '{ERR_NONE, 5'd1});
        add_row(base_beat(1'b0, 2'd2, '1, ERR_NONE), 1'b0, none);
        add_row(base_beat(1'b0, 2'd3, '0, ERR_SUBST), 1'b1, '{ERR_SUBST, 5'd1});
        add_row(base_beat(1'b0, 2'd3, '0, ERR_NONE), 1'b0, none);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [APB_DW-1:0] cfg_vals [8];
        t_result           none;
        none             = '0;
        i_rst_n          = 1'b0;
        i_valid          = 1'b0;
        i_stall          = 1'b0;
        i_req_type       = REQ_BASE;
        i_new_read       = 1'b0;
        i_base           = '0;
        i_random_value   = '0;
        i_prior_error    = '0;
        i_entry_index    = '0;
        i_deletion_rate  = '0;
        i_insertion_rate = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        pin_on           = 1'b0;
        pin_res          = '0;
        fail_count       = 0;
        results_seen     = 0;
        cycle_count      = 0;
        long_hold_done   = 1'b0;
        run_left         = 0;
        run_base         = '0;
        track_base       = '0;
        track_active     = 1'b0;
        track_len        = '0;
        track_dir        = DIR_NONE;
        entries_cfg      = 5'd1;
        for (int i = 0; i < DEPTH; i++) begin
            del_rates[i] = '0;
            ins_rates[i] = '0;
        end
        // settings: full depth, zero, above depth, small, masked upper bits, two random, one
        cfg_vals = '{32'd16, 32'd0, 32'd31, 32'd2, 32'hFFFF_FFE5,
                     32'($urandom_range(1, 16)), 32'($urandom_range(1, 16)), 32'd1};

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        fill_directed();
        foreach (directed_rows[i])
            send_beat(directed_rows[i].beat, directed_rows[i].pinned, directed_rows[i].res);

        foreach (cfg_vals[p]) begin
            drain();
            set_table_entries(cfg_vals[p]);
            repeat (PHASE_BEATS)
                send_beat(next_random_beat(), 1'b0, none);
        end

        i_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending_results.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: homopolymer_indel_injector.f
sv/hpi_pkg.sv
sv/hpi_ram.sv
sv/hpi_run_track.sv
sv/hpi_indel_decide.sv
sv/homopolymer_indel_injector.sv
tb/tb_homopolymer_indel_injector.sv
